[rtl/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// h2r_pkg: shared types and constants for the HSV to RGB converter
// Holds the fixed-point scale constants, sector codes and the pixel types.
// ----------------------------------------------------------------------------
package h2r_pkg;

    // Field widths
    localparam int HUE_W = 15;
    localparam int CH_W  = 8;

    // One sector spans 3840 hue units (60 degrees at 1/64 degree each)
    localparam logic [11:0] SECTOR_SIZE = 12'd3840;
    localparam logic [7:0]  FULL_SCALE  = 8'd255;
    localparam logic [19:0] FRAC_SCALE  = 20'd979200;   // 255 * 3840

    // Sector number: floor((hue >> 8) / 15) == ((hue >> 8) * 137) >> 11
    localparam logic [7:0]  SEC_RECIP   = 8'd137;
    localparam int          SEC_SHIFT   = 11;

    // floor(y / 3825) == (y * 1122868) >> 32 for y below 2^20
    localparam logic [20:0] LVL_RECIP   = 21'd1122868;
    localparam int          LVL_SHIFT   = 32;

    // Sector codes
    localparam logic [3:0] SEC_RED_YEL = 4'd0;
    localparam logic [3:0] SEC_YEL_GRN = 4'd1;
    localparam logic [3:0] SEC_GRN_CYN = 4'd2;
    localparam logic [3:0] SEC_CYN_BLU = 4'd3;
    localparam logic [3:0] SEC_BLU_MAG = 4'd4;

    // Output pixel, red in the lowest bits
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgb;

    // Input pixel, hue in the lowest bits, one pad bit on top
    typedef struct packed {
        logic            pad;
        logic [CH_W-1:0] value;
        logic [CH_W-1:0] saturation;
        logic [HUE_W-1:0] hue;
    } t_hsv;

endpackage

[rtl/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter: fixed-point HSV to RGB pixel converter
// Six-stage pipeline: sector split, products, level differences, scaling,
// reciprocal division and channel routing.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   32     hue[14:0], saturation[22:15], value[30:23]
//  m_axis    out  24     red[7:0], green[15:8], blue[23:16]
//
//  One pixel is taken every cycle while the output is drained.
//  The whole pipeline advances together; it holds when the output register is
//  full and not taken, so o_s_axis_tready is low only in that case.
//  Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // hue[14:0], saturation[22:15], value[30:23]
    // output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import h2r_pkg::*;

    localparam int NSTG = 6;

    t_hsv        w_in;
    logic        w_en;
    logic        w_acc;

    logic [NSTG-1:0] r_vld;

    // stage 1
    logic [14:0] w_sec_prod;
    logic [3:0]  w_sector;
    logic [15:0] w_sec_base;
    logic [15:0] w_frac_full;
    logic [3:0]  r1_sector;
    logic [11:0] r1_frac;
    logic [7:0]  r1_s;
    logic [7:0]  r1_v;
    logic [15:0] r1_pnum;

    // stage 2
    logic [11:0] w_frac_inv;
    logic [16:0] w_p_sum;
    logic [3:0]  r2_sector;
    logic [7:0]  r2_v;
    logic [7:0]  r2_p;
    logic [19:0] r2_prod_q;
    logic [19:0] r2_prod_t;

    // stage 3
    logic [3:0]  r3_sector;
    logic [7:0]  r3_v;
    logic [7:0]  r3_p;
    logic [19:0] r3_diff_q;
    logic [19:0] r3_diff_t;

    // stage 4
    logic [3:0]  r4_sector;
    logic [7:0]  r4_v;
    logic [7:0]  r4_p;
    logic [27:0] r4_num_q;
    logic [27:0] r4_num_t;

    // stage 5
    logic [40:0] w_quo_q;
    logic [40:0] w_quo_t;
    logic [3:0]  r5_sector;
    logic [7:0]  r5_v;
    logic [7:0]  r5_p;
    logic [7:0]  r5_q;
    logic [7:0]  r5_t;

    // stage 6
    t_rgb        n_rgb;
    t_rgb        r6_rgb;

    assign w_in = t_hsv'(i_s_axis_tdata);

    // Advance the whole pipeline unless the output holds an untaken transaction
    assign w_en            = !r_vld[NSTG-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_acc           = i_s_axis_tvalid && w_en;

    // Move valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], w_acc};
        end
    end

    // Stage 1: split hue into sector and fraction, form v*(255-s)
    assign w_sec_prod  = 15'(w_in.hue[14:8] * SEC_RECIP);
    assign w_sector    = w_sec_prod[14:SEC_SHIFT];
    assign w_sec_base  = 16'(w_sector * SECTOR_SIZE);
    assign w_frac_full = {1'b0, w_in.hue} - w_sec_base;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sector <= w_sector;
            r1_frac   <= w_frac_full[11:0];
            r1_s      <= w_in.saturation;
            r1_v      <= w_in.value;
            r1_pnum   <= 16'(w_in.value * (FULL_SCALE - w_in.saturation));
        end
    end

    // Stage 2: s*frac and s*(3840-frac); p = floor(pnum / 255)
    assign w_frac_inv = SECTOR_SIZE - r1_frac;
    assign w_p_sum    = {1'b0, r1_pnum} + 17'(r1_pnum[15:8]) + 17'd1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sector <= r1_sector;
            r2_v      <= r1_v;
            r2_p      <= w_p_sum[15:8];
            r2_prod_q <= 20'(r1_s * r1_frac);
            r2_prod_t <= 20'(r1_s * w_frac_inv);
        end
    end

    // Stage 3: distance of each product from full scale
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sector <= r2_sector;
            r3_v      <= r2_v;
            r3_p      <= r2_p;
            r3_diff_q <= FRAC_SCALE - r2_prod_q;
            r3_diff_t <= FRAC_SCALE - r2_prod_t;
        end
    end

    // Stage 4: scale by value
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sector <= r3_sector;
            r4_v      <= r3_v;
            r4_p      <= r3_p;
            r4_num_q  <= 28'(r3_v * r3_diff_q);
            r4_num_t  <= 28'(r3_v * r3_diff_t);
        end
    end

    // Stage 5: divide by 979200 as a shift by 8 then a reciprocal multiply
    assign w_quo_q = 41'(r4_num_q[27:8] * LVL_RECIP);
    assign w_quo_t = 41'(r4_num_t[27:8] * LVL_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_sector <= r4_sector;
            r5_v      <= r4_v;
            r5_p      <= r4_p;
            r5_q      <= w_quo_q[LVL_SHIFT+7:LVL_SHIFT];
            r5_t      <= w_quo_t[LVL_SHIFT+7:LVL_SHIFT];
        end
    end

    // Stage 6: route levels to channels; zero saturation makes p, q, t equal v
    always_comb begin
        unique case (r5_sector)
            SEC_RED_YEL: n_rgb = '{blue: r5_p, green: r5_t, red: r5_v};
            SEC_YEL_GRN: n_rgb = '{blue: r5_p, green: r5_v, red: r5_q};
            SEC_GRN_CYN: n_rgb = '{blue: r5_t, green: r5_v, red: r5_p};
            SEC_CYN_BLU: n_rgb = '{blue: r5_v, green: r5_q, red: r5_p};
            SEC_BLU_MAG: n_rgb = '{blue: r5_v, green: r5_p, red: r5_t};
            default:     n_rgb = '{blue: r5_q, green: r5_p, red: r5_v};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_rgb <= n_rgb;
        end
    end

    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = r6_rgb;

`ifndef SYNTHESIS
    // Pipeline never refuses input while the output register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output register");

    // Fraction stays inside one sector
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r1_frac < SECTOR_SIZE) && (r1_sector <= 4'd8))
        else $error("sector split out of range");

    // p never exceeds value
    a_p_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> r2_p <= r2_v)
        else $error("level p above value");

    // q and t never exceed value
    a_qt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r5_q <= r5_v) && (r5_t <= r5_v))
        else $error("level q or t above value");

    // An accepted transaction reaches the output when the pipeline is never stalled
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_en) ##1 w_en ##1 w_en ##1 w_en ##1 w_en ##1 w_en |=> o_m_axis_tvalid)
        else $error("transaction lost in pipeline");
`endif

endmodule
